// ----- design/olp_pkg.sv -----
// Package for the ordered list block: sizes, command, status, cell and state codes,
// and the control struct that the controller hands to the cell row.
// No dependencies.
package olp_pkg;

  localparam int CAPACITY = 32;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_DELETE     = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_NOOP  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_FROM_FRONT
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic             apply;    // command changes the list this cycle
    cmd_t             cmd;
    logic             rotate;   // one dump step: rotate active cells by one
    logic [LEN_W-1:0] len;      // current length
    logic [IDX_W-1:0] del_idx;
  } ctl_t;

endpackage

// ----- design/olp_if.sv -----
// Handshake channels for the ordered list block: command words in, list words out.
// Depends on olp_pkg.
interface olp_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic signed [olp_pkg::DATA_W-1:0] operand;

  modport source (output valid, output command, output operand, input ready);
  modport sink   (input valid, input command, input operand, output ready);
endinterface

interface olp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic signed [olp_pkg::DATA_W-1:0] element;
  logic                         last;
  logic                         empty_res;
  logic [1:0]                   status;

  modport source (output valid, output element, output last, output empty_res,
                  output status, input ready);
  modport sink   (input valid, input element, input last, input empty_res,
                  input status, output ready);
endinterface

// ----- design/olp_cell.sv -----
// One cell of the list row: holds one element and takes a new value from the
// operand or a neighbor as the control says. Depends on olp_pkg.
module olp_cell (
  input  logic                          clk,
  input  olp_pkg::cell_op_t             op,
  input  logic [olp_pkg::DATA_W-1:0]    operand,
  input  logic [olp_pkg::DATA_W-1:0]    left_data,
  input  logic [olp_pkg::DATA_W-1:0]    right_data,
  input  logic [olp_pkg::DATA_W-1:0]    front_data,
  output logic [olp_pkg::DATA_W-1:0]    data
);

  logic [olp_pkg::DATA_W-1:0] data_next;

  always_comb begin
    case (op)
      olp_pkg::CELL_LOAD:       data_next = operand;
      olp_pkg::CELL_FROM_LEFT:  data_next = left_data;
      olp_pkg::CELL_FROM_RIGHT: data_next = right_data;
      olp_pkg::CELL_FROM_FRONT: data_next = front_data;
      default:                  data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ----- design/olp_ctrl.sv -----
// Controller of the ordered list: command decode, length, dump counter and the
// handshake state machine. Depends on olp_pkg.
module olp_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [1:0]                    in_command,
  input  logic [olp_pkg::DATA_W-1:0]    in_operand,
  output logic                          in_ready,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_last,
  output logic                          out_empty,
  output olp_pkg::status_t              out_status,
  output olp_pkg::ctl_t                 ctl
);

  olp_pkg::state_t               state, state_next;
  logic [olp_pkg::LEN_W-1:0]     len, len_next;
  logic [olp_pkg::LEN_W-1:0]     cnt, cnt_next;
  olp_pkg::status_t              status, status_next;
  olp_pkg::cmd_t                 cmd;
  logic                          in_fire, out_fire;
  logic                          full, range_bad, apply;

  assign cmd       = olp_pkg::cmd_t'(in_command);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign full      = (len == olp_pkg::LEN_W'(olp_pkg::CAPACITY));
  // negative index has the top bit set, so it is never below the length
  assign range_bad = (in_operand >= {{(olp_pkg::DATA_W - olp_pkg::LEN_W){1'b0}}, len});

  always_comb begin
    status_next = status;
    len_next    = len;
    apply       = 1'b0;
    if (in_fire) begin
      case (cmd)
        olp_pkg::CMD_PUSH_FRONT, olp_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            status_next = olp_pkg::STAT_FULL;
          end else begin
            status_next = olp_pkg::STAT_DONE;
            len_next    = len + olp_pkg::LEN_W'(1);
            apply       = 1'b1;
          end
        end
        olp_pkg::CMD_DELETE: begin
          if (range_bad) begin
            status_next = olp_pkg::STAT_RANGE;
          end else begin
            status_next = olp_pkg::STAT_DONE;
            len_next    = len - olp_pkg::LEN_W'(1);
            apply       = 1'b1;
          end
        end
        default: status_next = olp_pkg::STAT_NOOP;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      olp_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = olp_pkg::ST_DUMP;
          cnt_next   = '0;
        end
      end
      olp_pkg::ST_DUMP: begin
        if (out_fire) begin
          cnt_next = cnt + olp_pkg::LEN_W'(1);
          if (out_last) begin
            state_next = olp_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = olp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    case (state)
      olp_pkg::ST_IDLE: in_ready  = 1'b1;
      olp_pkg::ST_DUMP: out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  assign out_empty  = (len == '0);
  assign out_last   = out_empty || (cnt == len - olp_pkg::LEN_W'(1));
  assign out_status = status;

  assign ctl.apply   = apply;
  assign ctl.cmd     = cmd;
  assign ctl.rotate  = out_fire && !out_empty;
  assign ctl.len     = len;
  assign ctl.del_idx = in_operand[olp_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= olp_pkg::ST_IDLE;
      len    <= '0;
      cnt    <= '0;
      status <= olp_pkg::STAT_DONE;
    end else begin
      state  <= state_next;
      len    <= len_next;
      cnt    <= cnt_next;
      status <= status_next;
    end
  end

endmodule

// ----- design/ordered_list_push_delete_dump.sv -----
// Ordered list top level: controller plus a row of CAPACITY cells; depends on
// olp_pkg, olp_if, olp_cell and olp_ctrl.
// A command word is taken and applied at once to the cell row. The dump then
// gives max(1, length) words, one per cycle while rsp.ready is high, by
// rotating the row. No new command is taken during a dump. Reset clears length
// and control state; cells are not reset.
module ordered_list_push_delete_dump (
  input logic       clk,
  input logic       rst,
  olp_req_if.sink   req,
  olp_rsp_if.source rsp
);

  olp_pkg::ctl_t              ctl;
  olp_pkg::status_t           status;
  logic [olp_pkg::DATA_W-1:0] cell_data [olp_pkg::CAPACITY];

  olp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .in_operand (req.operand),
    .in_ready   (req.ready),
    .out_ready  (rsp.ready),
    .out_valid  (rsp.valid),
    .out_last   (rsp.last),
    .out_empty  (rsp.empty_res),
    .out_status (status),
    .ctl        (ctl)
  );

  genvar j;
  generate
    for (j = 0; j < olp_pkg::CAPACITY; j++) begin : g_cell
      logic [olp_pkg::DATA_W-1:0] left_data, right_data;
      olp_pkg::cell_op_t          cell_op;

      if (j == 0) begin : g_first
        assign left_data = '0;
      end else begin : g_mid_l
        assign left_data = cell_data[j-1];
      end
      if (j == olp_pkg::CAPACITY - 1) begin : g_end
        assign right_data = '0;
      end else begin : g_mid_r
        assign right_data = cell_data[j+1];
      end

      always_comb begin
        cell_op = olp_pkg::CELL_HOLD;
        if (ctl.apply) begin
          case (ctl.cmd)
            olp_pkg::CMD_PUSH_FRONT:
              cell_op = (j == 0) ? olp_pkg::CELL_LOAD : olp_pkg::CELL_FROM_LEFT;
            olp_pkg::CMD_PUSH_BACK:
              if (olp_pkg::LEN_W'(j) == ctl.len) cell_op = olp_pkg::CELL_LOAD;
            olp_pkg::CMD_DELETE:
              if (olp_pkg::IDX_W'(j) >= ctl.del_idx) cell_op = olp_pkg::CELL_FROM_RIGHT;
            default: cell_op = olp_pkg::CELL_HOLD;
          endcase
        end else if (ctl.rotate) begin
          // wrap the front word into the last active cell
          if (olp_pkg::LEN_W'(j) == ctl.len - olp_pkg::LEN_W'(1)) begin
            cell_op = olp_pkg::CELL_FROM_FRONT;
          end else if (olp_pkg::LEN_W'(j) < ctl.len) begin
            cell_op = olp_pkg::CELL_FROM_RIGHT;
          end
        end
      end

      olp_cell u_cell (
        .clk        (clk),
        .op         (cell_op),
        .operand    (req.operand),
        .left_data  (left_data),
        .right_data (right_data),
        .front_data (cell_data[0]),
        .data       (cell_data[j])
      );
    end
  endgenerate

  assign rsp.element = rsp.empty_res ? '0 : cell_data[0];
  assign rsp.status  = status;

endmodule

// ----- design/olp_checker.sv -----
// Port-level checks for the ordered list top level, bound to it below.
// Depends on olp_pkg.
module olp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [olp_pkg::DATA_W-1:0] rsp_element,
  input logic                       rsp_last,
  input logic                       rsp_empty_res
);

  // one command at a time: no new word while a dump is out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("command taken during dump");

  a_dump_follows: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> rsp_valid)
    else $error("no dump after command");

  a_empty_single: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_empty_res) |-> (rsp_last && rsp_element == '0))
    else $error("empty dump is not a single zero word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_element)))
    else $error("stalled output word changed");

endmodule

bind ordered_list_push_delete_dump olp_checker u_olp_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_element   (rsp.element),
  .rsp_last      (rsp.last),
  .rsp_empty_res (rsp.empty_res)
);
